@@ rtl/mi4_pkg.sv @@
`timescale 1ns / 1ps
package mi4_pkg;

  // Element format and default fraction width.
  localparam int ELEM_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  // Whole matrix, element (r, c) at index {r, c}.
  typedef logic [15:0][ELEM_WIDTH-1:0] mat_t;

  typedef struct packed {
    logic [1:0]                   row_index;
    logic signed [ELEM_WIDTH-1:0] elem_col0;
    logic signed [ELEM_WIDTH-1:0] elem_col1;
    logic signed [ELEM_WIDTH-1:0] elem_col2;
    logic signed [ELEM_WIDTH-1:0] elem_col3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   out_row;
    logic signed [ELEM_WIDTH-1:0] inv_col0;
    logic signed [ELEM_WIDTH-1:0] inv_col1;
    logic signed [ELEM_WIDTH-1:0] inv_col2;
    logic signed [ELEM_WIDTH-1:0] inv_col3;
    logic                         singular;
    logic                         last_row;
  } out_word_t;

  // Status of a multi-cycle arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_GO,
    BK_MUL_WAIT,
    BK_DET_GO,
    BK_DET_WAIT,
    BK_CHK,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_PUSH
  } back_state_t;

  // The n-th index of 0..3 once index s is left out.
  function automatic logic [1:0] skip_idx(input logic [1:0] s, input logic [1:0] n);
    return (n < s) ? n : n + 2'd1;
  endfunction

endpackage

@@ rtl/mi4_queue.sv @@
`timescale 1ns / 1ps
module mi4_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         q_full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         q_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage is written at the write pointer only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

@@ rtl/mi4_mul.sv @@
`timescale 1ns / 1ps
module mi4_mul #(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [AW-1:0]  a,
  input  logic signed [BW-1:0]  b,
  output logic signed [AW-1:0]  p,
  output mi4_pkg::unit_stat_t   stat
);
  import mi4_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] ma_r, ma_nxt, acc_r, acc_nxt;
  logic [BW-1:0] mb_r, mb_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;

  assign p         = neg_r ? -$signed(acc_r) : $signed(acc_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // Shift and add over the magnitude of b, one bit a cycle.
  always_comb begin
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      ma_nxt   = a[AW-1] ? AW'(-a) : AW'(a);
      mb_nxt   = b[BW-1] ? BW'(-b) : BW'(b);
      acc_nxt  = '0;
      cnt_nxt  = CW'(BW);
      neg_nxt  = a[AW-1] ^ b[BW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mb_r[0]) begin
        acc_nxt = acc_r + ma_r;
      end
      ma_nxt  = ma_r << 1;
      mb_nxt  = mb_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

endmodule

@@ rtl/mi4_div.sv @@
`timescale 1ns / 1ps
module mi4_div #(
  parameter int NW = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [NW-1:0]       den,
  output logic [NW-1:0]       quo,
  output mi4_pkg::unit_stat_t stat
);
  import mi4_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] rem_r, rem_nxt, q_r, q_nxt, den_r, den_nxt;
  logic [NW:0]   trial;
  logic          ge;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  assign quo       = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign trial     = {rem_r, q_r[NW-1]};
  assign ge        = (trial >= {1'b0, den_r});

  // Restoring division, one quotient bit a cycle, numerator shifted in.
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? NW'(trial - {1'b0, den_r}) : NW'(trial);
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

@@ rtl/mi4_front.sv @@
`timescale 1ns / 1ps
module mi4_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  mi4_pkg::in_word_t in_word,
  input  logic              job_pop,
  output logic              job_valid,
  output mi4_pkg::mat_t     job
);
  import mi4_pkg::*;

  elem_t [3:0] rows_r [3];
  elem_t [3:0] in_row;
  mat_t        job_in;
  logic        accept, job_empty;

  assign accept    = push && !full;
  assign in_row    = {in_word.elem_col3, in_word.elem_col2,
                      in_word.elem_col1, in_word.elem_col0};
  assign job_valid = !job_empty;

  // A row 3 word completes the matrix with the three stored rows.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      job_in[c]      = rows_r[0][c];
      job_in[4 + c]  = rows_r[1][c];
      job_in[8 + c]  = rows_r[2][c];
      job_in[12 + c] = in_row[c];
    end
  end

  // Rows 0 to 2 are held here until the last row arrives.
  always_ff @(posedge clk) begin
    if (accept && (in_word.row_index != 2'd3)) begin
      rows_r[in_word.row_index] <= in_row;
    end
  end

  mi4_queue #(
    .W     ($bits(mat_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_word.row_index == 2'd3)),
    .wr_data (job_in),
    .q_full  (full),
    .rd_en   (job_pop),
    .rd_data (job),
    .q_empty (job_empty)
  );

endmodule

@@ rtl/mi4_back.sv @@
`timescale 1ns / 1ps
module mi4_back #(
  parameter int FRAC_BITS = 16,
  parameter int WW        = 168
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  job_valid,
  input  mi4_pkg::mat_t                         job,
  output logic                                  job_pop,
  output logic                                  mul_start,
  output logic signed [WW-1:0]                  mul_a,
  output logic signed [mi4_pkg::ELEM_WIDTH-1:0] mul_b,
  input  logic signed [WW-1:0]                  mul_p,
  input  mi4_pkg::unit_stat_t                   mul_stat,
  output logic                                  div_start,
  output logic [WW-1:0]                         div_num,
  output logic [WW-1:0]                         div_den,
  input  logic [WW-1:0]                         div_quo,
  input  mi4_pkg::unit_stat_t                   div_stat,
  input  logic                                  oq_full,
  output logic                                  oq_push,
  output mi4_pkg::out_word_t                    oq_word
);
  import mi4_pkg::*;

  localparam int E = ELEM_WIDTH;

  back_state_t        state_r, state_nxt;
  mat_t               m_r, m_nxt;
  logic signed [WW-1:0] cof_r [4][4];
  logic signed [WW-1:0] cof_nxt [4][4];
  logic signed [WW-1:0] det_r, det_nxt, tacc_r, tacc_nxt, dacc_r, dacc_nxt, dsum, cur_c;
  logic [1:0]         ci_r, ci_nxt, cj_r, cj_nxt, k_r, k_nxt, ph_r, ph_nxt;
  logic [1:0]         oj_r, oj_nxt, orow_r, orow_nxt;
  elem_t              cols_r [4];
  elem_t              cols_nxt [4];
  logic               sing_r, sing_nxt;
  logic [1:0]         r0, r1, r2, c0, c1, c2, ca, cb, ck;

  function automatic logic signed [WW-1:0] sx(input elem_t x);
    return {{(WW - E){x[E-1]}}, x};
  endfunction

  function automatic logic [WW-1:0] absw(input logic signed [WW-1:0] x);
    return x[WW-1] ? WW'(-x) : WW'(x);
  endfunction

  // Clamp a magnitude to the element range and apply the sign.
  function automatic elem_t sat(input logic [WW-1:0] mag, input logic neg);
    logic [WW-1:0] lim;
    logic [WW-1:0] mx;
    logic [WW-1:0] low;
    lim = WW'(1) << (E - 1);
    mx  = neg ? lim : lim - WW'(1);
    low = (mag > mx) ? mx : mag;
    return neg ? E'(-low) : E'(low);
  endfunction

  // Rows and columns of the 3x3 minor left after striking ci and cj.
  always_comb begin
    r0 = skip_idx(ci_r, 2'd0);
    r1 = skip_idx(ci_r, 2'd1);
    r2 = skip_idx(ci_r, 2'd2);
    c0 = skip_idx(cj_r, 2'd0);
    c1 = skip_idx(cj_r, 2'd1);
    c2 = skip_idx(cj_r, 2'd2);
    case (k_r)
      2'd0: begin
        ca = c1; cb = c2; ck = c0;
      end
      2'd1: begin
        ca = c0; cb = c2; ck = c1;
      end
      default: begin
        ca = c0; cb = c1; ck = c2;
      end
    endcase
  end

  // Multiplier operands: a 2x2 product, the 2x2 minor times a row r0 element or a determinant term.
  always_comb begin
    if (state_r inside {BK_DET_GO, BK_DET_WAIT}) begin
      mul_a = cof_r[0][oj_r];
      mul_b = m_r[{2'd0, oj_r}];
    end else begin
      case (ph_r)
        2'd0: begin
          mul_a = sx(m_r[{r1, ca}]);
          mul_b = m_r[{r2, cb}];
        end
        2'd1: begin
          mul_a = sx(m_r[{r1, cb}]);
          mul_b = m_r[{r2, ca}];
        end
        default: begin
          mul_a = tacc_r;
          mul_b = m_r[{r0, ck}];
        end
      endcase
    end
  end

  // Divider operands: transposed cofactor scaled up, over the determinant.
  assign cur_c   = cof_r[oj_r][orow_r];
  assign div_num = absw(cur_c) << (2 * FRAC_BITS);
  assign div_den = absw(det_r);
  assign dsum    = (k_r == 2'd1) ? dacc_r - mul_p : dacc_r + mul_p;

  always_comb begin
    oq_word.out_row  = orow_r;
    oq_word.inv_col0 = cols_r[0];
    oq_word.inv_col1 = cols_r[1];
    oq_word.inv_col2 = cols_r[2];
    oq_word.inv_col3 = cols_r[3];
    oq_word.singular = sing_r;
    oq_word.last_row = (orow_r == 2'd3);
  end

  // Sequencer: cofactors, determinant, then four rows of quotients (of the scaled adjugate if singular).
  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    cof_nxt   = cof_r;
    det_nxt   = det_r;
    tacc_nxt  = tacc_r;
    dacc_nxt  = dacc_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    oj_nxt    = oj_r;
    orow_nxt  = orow_r;
    cols_nxt  = cols_r;
    sing_nxt  = sing_r;
    job_pop   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    oq_push   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          m_nxt     = job;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
          k_nxt     = 2'd0;
          ph_nxt    = 2'd0;
          dacc_nxt  = '0;
          state_nxt = BK_MUL_GO;
        end
      end
      BK_MUL_GO: begin
        mul_start = 1'b1;
        state_nxt = BK_MUL_WAIT;
      end
      BK_MUL_WAIT: begin
        if (mul_stat.done) begin
          state_nxt = BK_MUL_GO;
          case (ph_r)
            2'd0: begin
              tacc_nxt = mul_p;
              ph_nxt   = 2'd1;
            end
            2'd1: begin
              tacc_nxt = tacc_r - mul_p;
              ph_nxt   = 2'd2;
            end
            default: begin
              ph_nxt = 2'd0;
              if (k_r == 2'd2) begin
                cof_nxt[ci_r][cj_r] = (ci_r[0] ^ cj_r[0]) ? -dsum : dsum;
                dacc_nxt = '0;
                k_nxt    = 2'd0;
                if (cj_r == 2'd3) begin
                  cj_nxt = 2'd0;
                  ci_nxt = ci_r + 2'd1;
                end else begin
                  cj_nxt = cj_r + 2'd1;
                end
                if ((ci_r == 2'd3) && (cj_r == 2'd3)) begin
                  oj_nxt    = 2'd0;
                  det_nxt   = '0;
                  state_nxt = BK_DET_GO;
                end
              end else begin
                dacc_nxt = dsum;
                k_nxt    = k_r + 2'd1;
              end
            end
          endcase
        end
      end
      BK_DET_GO: begin
        mul_start = 1'b1;
        state_nxt = BK_DET_WAIT;
      end
      BK_DET_WAIT: begin
        if (mul_stat.done) begin
          det_nxt = det_r + mul_p;
          if (oj_r == 2'd3) begin
            state_nxt = BK_CHK;
          end else begin
            oj_nxt    = oj_r + 2'd1;
            state_nxt = BK_DET_GO;
          end
        end
      end
      BK_CHK: begin
        sing_nxt  = (det_r == '0);
        orow_nxt  = 2'd0;
        oj_nxt    = 2'd0;
        state_nxt = BK_DIV_GO;
      end
      BK_DIV_GO: begin
        if (sing_r) begin
          // Singular matrix: the adjugate itself, scaled back to the format.
          cols_nxt[oj_r] = sat(absw(cur_c) >> (2 * FRAC_BITS), cur_c[WW-1]);
          if (oj_r == 2'd3) begin
            state_nxt = BK_PUSH;
          end else begin
            oj_nxt = oj_r + 2'd1;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = BK_DIV_WAIT;
        end
      end
      BK_DIV_WAIT: begin
        if (div_stat.done) begin
          cols_nxt[oj_r] = sat(div_quo, cur_c[WW-1] ^ det_r[WW-1]);
          if (oj_r == 2'd3) begin
            state_nxt = BK_PUSH;
          end else begin
            oj_nxt    = oj_r + 2'd1;
            state_nxt = BK_DIV_GO;
          end
        end
      end
      BK_PUSH: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          oj_nxt  = 2'd0;
          if (orow_r == 2'd3) begin
            state_nxt = BK_IDLE;
          end else begin
            orow_nxt  = orow_r + 2'd1;
            state_nxt = BK_DIV_GO;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    cof_r  <= cof_nxt;
    det_r  <= det_nxt;
    tacc_r <= tacc_nxt;
    dacc_r <= dacc_nxt;
    ci_r   <= ci_nxt;
    cj_r   <= cj_nxt;
    k_r    <= k_nxt;
    ph_r   <= ph_nxt;
    oj_r   <= oj_nxt;
    orow_r <= orow_nxt;
    cols_r <= cols_nxt;
    sing_r <= sing_nxt;
  end

endmodule

@@ rtl/matrix_inverse_4x4.sv @@
`timescale 1ns / 1ps
// 4x4 matrix inverse by the adjugate, signed fixed point.
// Input channel: write one matrix row per word with push while full is low.
// Rows 0 to 2 are only stored. A row 3 word hands the completed matrix to a
// two-deep job queue, so a second matrix can be loaded while the first is being
// worked on.
// Result channel: four words, rows 0 to 3 of the inverse, are read from a
// two-deep output queue with pop while empty is low; last_row marks row 3 and
// singular marks a zero determinant, in which case the scaled adjugate is given.
// The cofactors and the determinant are formed on one serial shift-and-add
// multiplier and the quotients on a bit-serial divider, both of width
// WW = 4*ELEM_WIDTH + 2*FRAC_BITS + 8. One matrix is worked on at a time.
// Reset clears the queues and the sequencer; stored rows are not cleared.
// When the receiver stops popping, the back end waits with a finished row and
// then the job queue fills and full goes high.
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  mi4_pkg::in_word_t  in_word,
  input  logic               pop,
  output logic               empty,
  output mi4_pkg::out_word_t out_word
);
  import mi4_pkg::*;

  localparam int WW = 4 * ELEM_WIDTH + 2 * FRAC_BITS + 8;

  logic                         job_valid, job_pop;
  mat_t                         job;
  logic                         mul_start, div_start, oq_push, oq_full;
  logic signed [WW-1:0]         mul_a, mul_p;
  logic signed [ELEM_WIDTH-1:0] mul_b;
  logic [WW-1:0]                div_num, div_den, div_quo;
  unit_stat_t                   mul_stat, div_stat;
  out_word_t                    oq_word;

  mi4_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  mi4_mul #(
    .AW (WW),
    .BW (ELEM_WIDTH)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .stat  (mul_stat)
  );

  mi4_div #(
    .NW (WW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  mi4_back #(
    .FRAC_BITS (FRAC_BITS),
    .WW        (WW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .mul_start (mul_start),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p),
    .mul_stat  (mul_stat),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_quo   (div_quo),
    .div_stat  (div_stat),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_word   (oq_word)
  );

  // Result queue parts the back end from the receiver.
  mi4_queue #(
    .W     ($bits(out_word_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_word),
    .q_full  (oq_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .q_empty (empty)
  );

  // The multiplier and the divider are never at work together.
  a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // A job is only taken when one is waiting.
  a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job taken from an empty queue");

  // The last-row flag marks exactly row 3 of the inverse.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_word.last_row == (out_word.out_row == 2'd3)))
    else $error("last_row does not match out_row");

endmodule
